[hw/rtl/erl_pkg.sv]
// Shared types, codes and field widths of the error record log table.
`default_nettype none

package erl_pkg;

	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned LINE_W     = 16;
	localparam int unsigned FILE_W     = 64;
	localparam int unsigned IDX_IN_W   = 8;
	localparam int unsigned TOTAL_W    = 16;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 136;

	localparam logic [IDX_IN_W-1:0] NO_SLOT   = 8'hFF;
	localparam logic [COUNT_W-1:0]  COUNT_MAX = 8'hFF;

	localparam logic [KIND_W-1:0] KIND_STORE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLR_ONE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLR_ALL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ONLINE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_EN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic                  ONLINE_RST    = 1'b0;
	localparam logic                  LOG_EN_RST    = 1'b1;
	localparam logic [COUNT_W-1:0]    THRESHOLD_RST = 8'd20;

	typedef logic [2:0] op_t;

	localparam op_t OP_FAIL    = 3'd0;
	localparam op_t OP_STORE   = 3'd1;
	localparam op_t OP_CLR_ONE = 3'd2;
	localparam op_t OP_CLR_ALL = 3'd3;
	localparam op_t OP_READ    = 3'd4;

	typedef struct packed {
		logic load;
		logic scan_issue;
		logic rd_slot;
		logic sweep;
		logic commit;
	} erl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_done;
		logic sweep_last;
		logic out_free;
	} erl_stat_t;

endpackage

`default_nettype wire

[hw/rtl/erl_ctrl.sv]
// Controller state machine that sequences decode, table scan, sweep and commit.
`default_nettype none

module erl_ctrl
	import erl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire erl_stat_t stat,
	output erl_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.op)
					OP_STORE:   state_nx = ST_SCAN;
					OP_CLR_ALL: state_nx = ST_SWEEP;
					OP_CLR_ONE, OP_READ: begin
						cmd.rd_slot = 1'b1;
						state_nx    = ST_FINISH;
					end
					default:    state_nx = ST_FINISH;
				endcase
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_done) begin
					state_nx = ST_FINISH;
				end
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/erl_dp.sv]
// Datapath with the record memory, valid bits, scan registers, totals and result register.
`default_nettype none

module erl_dp
	import erl_pkg::*;
#(
	parameter int unsigned SLOTS      = 32,
	parameter int unsigned NAME_BYTES = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire erl_cmd_t              cmd,
	output erl_stat_t                  stat,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [LINE_W-1:0]     line_number,
	input  wire logic [FILE_W-1:0]     file_code,
	input  wire logic                  is_fatal,
	input  wire logic [IDX_IN_W-1:0]   slot_index,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic                       status,
	output logic                       below_threshold,
	output logic [IDX_IN_W-1:0]        slot_used,
	output logic [COUNT_W-1:0]         record_count,
	output logic [LINE_W-1:0]          record_line,
	output logic [FILE_W-1:0]          record_file,
	output logic                       record_fatal,
	output logic [TOTAL_W-1:0]         unique_total,
	output logic [TOTAL_W-1:0]         dropped_total
);

	localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned NAME_W = 8 * NAME_BYTES;
	localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(SLOTS - 1);
	localparam logic [IDX_IN_W:0]   SLOTS_EXT = (IDX_IN_W + 1)'(SLOTS);

	typedef struct packed {
		logic              fatal;
		logic [NAME_W-1:0] name;
		logic [LINE_W-1:0] line;
		logic [COUNT_W-1:0] count;
	} rec_t;

	function automatic logic [NAME_W-1:0] norm_name(input logic [FILE_W-1:0] code);
		logic [NAME_W-1:0] r;
		logic              alive;
		r     = '0;
		alive = 1'b1;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (code[8*i +: 8] == 8'h00) begin
				alive = 1'b0;
			end
			if (alive) begin
				r[8*i +: 8] = code[8*i +: 8];
			end
		end
		return r;
	endfunction

	rec_t               mem [SLOTS];
	logic [SLOTS-1:0]   vld_q;

	logic               online_q;
	logic               log_en_q;
	logic [COUNT_W-1:0] thr_q;

	op_t                op_q;
	op_t                op_in;
	logic               in_range;
	logic               en;
	logic [LINE_W-1:0]  line_q;
	logic [NAME_W-1:0]  name_q;
	logic               fatal_q;
	logic [IDX_W-1:0]   idx_q;

	logic [IDX_W-1:0]   ptr_q;
	logic               issue_end_q;
	logic               scan_s1_q;
	logic [IDX_W-1:0]   idx_s1;
	rec_t               rd_s1;
	logic               issue;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;

	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic               hit_fatal_q;
	logic               have_empty_q;
	logic [IDX_W-1:0]   empty_q;
	logic               have_nf_q;
	logic [IDX_W-1:0]   nf_q;

	logic               live_s1;
	logic               match_s1;
	logic               eval;

	logic [IDX_W-1:0]   new_idx;
	logic               slot_live;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	rec_t               wr_rec;
	logic               set_vld;
	logic               clr_vld;
	logic [IDX_W-1:0]   vld_addr;
	logic               uniq_inc;
	logic               uniq_dec;
	logic               drop_inc;
	logic [TOTAL_W-1:0] unique_q;
	logic [TOTAL_W-1:0] dropped_q;
	logic [TOTAL_W-1:0] unique_nx;
	logic [TOTAL_W-1:0] dropped_nx;

	logic               r_status;
	logic               r_below;
	logic [IDX_IN_W-1:0] r_used;
	logic [COUNT_W-1:0] r_count;
	logic [LINE_W-1:0]  r_line;
	logic [FILE_W-1:0]  r_file;
	logic               r_fatal;
	logic               out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q <= ONLINE_RST;
			log_en_q <= LOG_EN_RST;
			thr_q    <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ONLINE:    online_q <= cfg_data[0];
				REG_LOG_EN:    log_en_q <= cfg_data[0];
				REG_THRESHOLD: thr_q    <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Operation decode at accept time.
	assign in_range = {1'b0, slot_index} < SLOTS_EXT;
	assign en       = online_q && log_en_q;

	always_comb begin
		op_in = OP_FAIL;
		unique case (kind)
			KIND_STORE:   op_in = en ? OP_STORE : OP_FAIL;
			KIND_CLR_ONE: begin
				if (slot_index == NO_SLOT) begin
					op_in = en ? OP_CLR_ALL : OP_FAIL;
				end else begin
					op_in = (en && in_range) ? OP_CLR_ONE : OP_FAIL;
				end
			end
			KIND_CLR_ALL: op_in = en ? OP_CLR_ALL : OP_FAIL;
			KIND_READ:    op_in = (online_q && in_range) ? OP_READ : OP_FAIL;
			default:      op_in = OP_FAIL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_FAIL;
		end else if (cmd.load) begin
			op_q <= op_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_q  <= line_number;
			name_q  <= norm_name(file_code);
			fatal_q <= is_fatal;
			idx_q   <= slot_index[IDX_W-1:0];
		end
	end

	// Scan pointer and read issue.
	assign issue   = cmd.scan_issue && !issue_end_q && !hit_q;
	assign rd_en   = issue || cmd.rd_slot;
	assign rd_addr = cmd.rd_slot ? idx_q : ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			issue_end_q <= 1'b0;
			scan_s1_q   <= 1'b0;
		end else if (cmd.load) begin
			ptr_q       <= '0;
			issue_end_q <= 1'b0;
			scan_s1_q   <= 1'b0;
		end else begin
			scan_s1_q <= issue;
			if (issue || cmd.sweep) begin
				if (ptr_q == LAST_IDX) begin
					issue_end_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
		if (issue) begin
			idx_s1 <= ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && cmd.commit) begin
			mem[wr_addr] <= wr_rec;
		end
	end

	// Evaluation of one scanned record per cycle.
	assign live_s1  = vld_q[idx_s1];
	assign match_s1 = live_s1 && (rd_s1.line == line_q) && (rd_s1.name == name_q);
	assign eval     = scan_s1_q && !hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			have_empty_q <= 1'b0;
			have_nf_q    <= 1'b0;
			hit_idx_q    <= '0;
			hit_cnt_q    <= '0;
			hit_fatal_q  <= 1'b0;
			empty_q      <= '0;
			nf_q         <= '0;
		end else if (cmd.load) begin
			hit_q        <= 1'b0;
			have_empty_q <= 1'b0;
			have_nf_q    <= 1'b0;
		end else if (eval) begin
			if (!have_nf_q && !(live_s1 && rd_s1.fatal)) begin
				have_nf_q <= 1'b1;
				nf_q      <= idx_s1;
			end
			if (!live_s1) begin
				if (!have_empty_q) begin
					have_empty_q <= 1'b1;
					empty_q      <= idx_s1;
				end
			end else if (match_s1) begin
				hit_q       <= 1'b1;
				hit_idx_q   <= idx_s1;
				hit_cnt_q   <= rd_s1.count;
				hit_fatal_q <= rd_s1.fatal;
			end
		end
	end

	// Final action and result of the operation.
	assign new_idx   = have_empty_q ? empty_q : nf_q;
	assign slot_live = vld_q[idx_q];

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = hit_idx_q;
		wr_rec   = '{fatal: hit_fatal_q, name: name_q, line: line_q,
			count: hit_cnt_q + 8'd1};
		set_vld  = 1'b0;
		clr_vld  = 1'b0;
		vld_addr = idx_q;
		uniq_inc = 1'b0;
		uniq_dec = 1'b0;
		drop_inc = 1'b0;
		r_status = 1'b1;
		r_used   = NO_SLOT;
		r_count  = '0;
		r_line   = '0;
		r_file   = '0;
		r_fatal  = 1'b0;
		unique case (op_q)
			OP_STORE: begin
				if (hit_q) begin
					r_used = IDX_IN_W'(hit_idx_q);
					if (hit_cnt_q == COUNT_MAX) begin
						drop_inc = 1'b1;
						r_count  = COUNT_MAX;
					end else begin
						wr_en    = 1'b1;
						r_status = 1'b0;
						r_count  = hit_cnt_q + 8'd1;
					end
				end else if (have_empty_q || (fatal_q && have_nf_q)) begin
					wr_en    = 1'b1;
					wr_addr  = new_idx;
					wr_rec   = '{fatal: fatal_q, name: name_q, line: line_q, count: 8'd1};
					set_vld  = 1'b1;
					vld_addr = new_idx;
					uniq_inc = 1'b1;
					r_status = 1'b0;
					r_used   = IDX_IN_W'(new_idx);
					r_count  = 8'd1;
				end else begin
					drop_inc = 1'b1;
				end
			end
			OP_CLR_ONE: begin
				r_status = 1'b0;
				r_used   = IDX_IN_W'(idx_q);
				if (slot_live) begin
					r_count  = rd_s1.count;
					clr_vld  = 1'b1;
					uniq_dec = 1'b1;
				end
			end
			OP_READ: begin
				r_status = 1'b0;
				r_used   = IDX_IN_W'(idx_q);
				if (slot_live) begin
					r_count = rd_s1.count;
					r_line  = rd_s1.line;
					r_file  = FILE_W'(rd_s1.name);
					r_fatal = rd_s1.fatal;
				end
			end
			OP_CLR_ALL: r_status = 1'b0;
			default: ;
		endcase
		r_below = (op_q == OP_STORE) && !r_status && (r_count <= thr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.sweep) begin
			vld_q[ptr_q] <= 1'b0;
		end else if (cmd.commit) begin
			if (set_vld) begin
				vld_q[vld_addr] <= 1'b1;
			end
			if (clr_vld) begin
				vld_q[vld_addr] <= 1'b0;
			end
		end
	end

	// Saturating totals.
	always_comb begin
		unique_nx  = unique_q;
		dropped_nx = dropped_q;
		if (cmd.sweep) begin
			if (vld_q[ptr_q] && (unique_q != '0)) begin
				unique_nx = unique_q - 1'b1;
			end
		end else if (cmd.commit) begin
			if (uniq_inc && (unique_q != '1)) begin
				unique_nx = unique_q + 1'b1;
			end else if (uniq_dec && (unique_q != '0)) begin
				unique_nx = unique_q - 1'b1;
			end
			if (drop_inc && (dropped_q != '1)) begin
				dropped_nx = dropped_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unique_q  <= '0;
			dropped_q <= '0;
		end else begin
			unique_q  <= unique_nx;
			dropped_q <= dropped_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status          <= r_status;
			below_threshold <= r_below;
			slot_used       <= r_used;
			record_count    <= r_count;
			record_line     <= r_line;
			record_file     <= r_file;
			record_fatal    <= r_fatal;
			unique_total    <= unique_nx;
			dropped_total   <= dropped_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.op         = op_q;
	assign stat.scan_done  = eval && (match_s1 || (idx_s1 == LAST_IDX));
	assign stat.sweep_last = (ptr_q == LAST_IDX);
	assign stat.out_free   = !out_valid_q || out_ready;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result committed while the output register is occupied");

	a_hit_live: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> vld_q[hit_idx_q])
		else $error("matching record is not live");

	a_unique_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.commit && !cmd.sweep) |=> $stable(unique_q))
		else $error("unique total changed outside sweep or commit");

	a_sweep_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> (op_q == OP_CLR_ALL))
		else $error("sweep issued for an operation other than clear all");

endmodule

`default_nettype wire

[hw/rtl/error_record_log_table_unit.sv]
// Top level of the error record log table: stream ports, configuration port and wiring.
//
// Usage: one command beat enters on the s_axis side; tuser carries the kind (store,
// clear one, clear all, read) and tdata the line, file code, fatal mark and slot index.
// Each command gives exactly one result beat on the m_axis side with status, threshold
// flag, slot, record fields and both totals. Configuration registers (online, log
// enable, count threshold) are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block itself does not enforce.
// Throughput: one command at a time. A store scans the record memory one slot per
// cycle through its single read port; it stops early at a matching record. Clear all
// sweeps the valid bits one slot per cycle. Read and clear one read only their own
// slot, and refused commands go straight to the result.
// Reset clears all records (valid bits) and both totals, and returns the configuration
// registers to their defaults: offline, logging enabled, threshold 20.
// A result that the receiver stalls stays in the output register; the next command is
// still accepted and worked up to its own result, which then waits for the register.
`default_nettype none

module error_record_log_table_unit
	import erl_pkg::*;
#(
	parameter int unsigned SLOTS      = 32,
	parameter int unsigned NAME_BYTES = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// line_number[15:0], file_code[79:16], is_fatal[80], slot_index[88:81], zero fill
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  wire logic [KIND_W-1:0]     s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// status[0], below_threshold[1], slot_used[9:2], record_count[17:10],
	// record_line[33:18], record_file[97:34], record_fatal[98], unique_total[114:99],
	// dropped_total[130:115], zero fill
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	erl_cmd_t            cmd;
	erl_stat_t           stat;
	logic                status;
	logic                below_threshold;
	logic [IDX_IN_W-1:0] slot_used;
	logic [COUNT_W-1:0]  record_count;
	logic [LINE_W-1:0]   record_line;
	logic [FILE_W-1:0]   record_file;
	logic                record_fatal;
	logic [TOTAL_W-1:0]  unique_total;
	logic [TOTAL_W-1:0]  dropped_total;

	erl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	erl_dp #(
		.SLOTS      (SLOTS),
		.NAME_BYTES (NAME_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.kind            (s_axis_tuser),
		.line_number     (s_axis_tdata[15:0]),
		.file_code       (s_axis_tdata[79:16]),
		.is_fatal        (s_axis_tdata[80]),
		.slot_index      (s_axis_tdata[88:81]),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.status          (status),
		.below_threshold (below_threshold),
		.slot_used       (slot_used),
		.record_count    (record_count),
		.record_line     (record_line),
		.record_file     (record_file),
		.record_fatal    (record_fatal),
		.unique_total    (unique_total),
		.dropped_total   (dropped_total)
	);

	assign m_axis_tdata = {5'b0, dropped_total, unique_total, record_fatal, record_file,
		record_line, record_count, slot_used, below_threshold, status};

endmodule

`default_nettype wire
